// ===== rtl/aoa_pkg.sv =====
`default_nettype none

package aoa_pkg;

    localparam int DEF_NUM_CHANNELS = 4;
    localparam int DEF_MAX_SAMPLES  = 64;

    localparam int SAMPLE_W  = 16;
    localparam int CLAMP_W   = 11;
    localparam int AVG_SHIFT = 4;
    localparam int AVG_W     = 15;
    localparam int REPORTED  = 4;

    localparam logic [CLAMP_W-1:0] CLAMP_TOP = 11'd2047;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_REPORT = 2'd1,
        ACT_RESYNC = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic sample_en;
        logic clear;
        logic phase_rst;
        logic q_clear;
        logic div_load;
        logic div_step;
        logic q_write;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_bit;
        logic last_ch;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/aoa_ctrl.sv =====
`default_nettype none

module aoa_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     action,
    input  wire aoa_pkg::sts_t  sts,
    output aoa_pkg::cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_STORE = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        aoa_pkg::ACT_SAMPLE:
                        begin
                            cmd.sample_en = 1'b1;
                        end
                        aoa_pkg::ACT_REPORT:
                        begin
                            cmd.q_clear = 1'b1;
                            state_next  = ST_LOAD;
                        end
                        aoa_pkg::ACT_RESYNC:
                        begin
                            cmd.clear     = 1'b1;
                            cmd.phase_rst = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.last_bit)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.q_write = 1'b1;
                state_next  = sts.last_ch ? ST_FIN : ST_LOAD;
            end
            ST_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aoa_datapath.sv =====
`default_nettype none

module aoa_datapath #(
    parameter int NUM_CHANNELS            = aoa_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_SAMPLES_PER_CHANNEL = aoa_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic signed [aoa_pkg::SAMPLE_W-1:0] sample,
    input  wire aoa_pkg::cmd_t                      cmd,
    output aoa_pkg::sts_t                           sts,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [aoa_pkg::AVG_W-1:0]               avg_ch0,
    output logic [aoa_pkg::AVG_W-1:0]               avg_ch1,
    output logic [aoa_pkg::AVG_W-1:0]               avg_ch2,
    output logic [aoa_pkg::AVG_W-1:0]               avg_ch3,
    output logic                                    dropped
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES_PER_CHANNEL + 1);
    localparam int TOT_W  = aoa_pkg::CLAMP_W + CNT_W;
    localparam int DIVD_W = TOT_W + aoa_pkg::AVG_SHIFT;
    localparam int BIT_W  = $clog2(DIVD_W);
    localparam int PH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RPT    = (NUM_CHANNELS < aoa_pkg::REPORTED) ? NUM_CHANNELS
                                                               : aoa_pkg::REPORTED;

    logic [TOT_W-1:0]  tot_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]  cnt_reg [NUM_CHANNELS];
    logic [PH_W-1:0]   phase_reg;
    logic              drop_reg;
    logic [PH_W-1:0]   ch_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              out_valid_reg;

    logic [DIVD_W-1:0] dvd_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [aoa_pkg::AVG_W-1:0] q_reg [aoa_pkg::REPORTED];
    logic [aoa_pkg::AVG_W-1:0] avg_reg [aoa_pkg::REPORTED];
    logic              dropped_reg;

    logic [PH_W-1:0]   addr;
    logic [TOT_W-1:0]  rd_tot;
    logic [CNT_W-1:0]  rd_cnt;
    logic [aoa_pkg::CLAMP_W-1:0] clamped;
    logic              at_cap;
    logic [PH_W-1:0]   phase_inc;
    logic [CNT_W:0]    shifted;
    logic [CNT_W+1:0]  trial;
    logic              qbit;

    // one read port: sample phase for a sample word, divider channel otherwise
    assign addr   = cmd.sample_en ? phase_reg : ch_reg;
    assign rd_tot = tot_reg[addr];
    assign rd_cnt = cnt_reg[addr];
    assign at_cap = (rd_cnt == CNT_W'(MAX_SAMPLES_PER_CHANNEL));

    always_comb
    begin
        if (sample[aoa_pkg::SAMPLE_W-1])
        begin
            clamped = '0;
        end
        else if (sample[aoa_pkg::SAMPLE_W-2:0]
                 >= {{(aoa_pkg::SAMPLE_W-1-aoa_pkg::CLAMP_W){1'b0}}, aoa_pkg::CLAMP_TOP})
        begin
            clamped = aoa_pkg::CLAMP_TOP;
        end
        else
        begin
            clamped = sample[aoa_pkg::CLAMP_W-1:0];
        end
    end

    assign phase_inc = (phase_reg == PH_W'(NUM_CHANNELS - 1)) ? '0 : phase_reg + 1'b1;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, dvd_reg[DIVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign qbit    = !trial[CNT_W+1];

    assign sts.last_bit = (bit_reg == '0);
    assign sts.last_ch  = (ch_reg == PH_W'(RPT - 1));
    assign sts.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                tot_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            phase_reg     <= '0;
            drop_reg      <= 1'b0;
            ch_reg        <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sample_en)
            begin
                if (at_cap)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    tot_reg[phase_reg] <= rd_tot + TOT_W'(clamped);
                    cnt_reg[phase_reg] <= rd_cnt + 1'b1;
                end
                phase_reg <= phase_inc;
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    tot_reg[i] <= '0;
                    cnt_reg[i] <= '0;
                end
                drop_reg <= 1'b0;
            end
            if (cmd.phase_rst)
            begin
                phase_reg <= '0;
            end
            if (cmd.q_clear)
            begin
                ch_reg <= '0;
            end
            if (cmd.div_load)
            begin
                bit_reg <= BIT_W'(DIVD_W - 1);
            end
            if (cmd.div_step)
            begin
                bit_reg <= bit_reg - 1'b1;
            end
            if (cmd.q_write)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg <= {rd_tot, {aoa_pkg::AVG_SHIFT{1'b0}}};
            dvs_reg <= rd_cnt;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIVD_W-2:0], qbit};
            rem_reg <= qbit ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
        for (int i = 0; i < aoa_pkg::REPORTED; i++)
        begin
            if (cmd.q_clear)
            begin
                q_reg[i] <= '0;
            end
            else if (cmd.q_write && (i < RPT) && (ch_reg == PH_W'(i)))
            begin
                q_reg[i] <= (dvs_reg == '0) ? '0 : quo_reg[aoa_pkg::AVG_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < aoa_pkg::REPORTED; i++)
            begin
                avg_reg[i] <= q_reg[i];
            end
            dropped_reg <= drop_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign avg_ch0   = avg_reg[0];
    assign avg_ch1   = avg_reg[1];
    assign avg_ch2   = avg_reg[2];
    assign avg_ch3   = avg_reg[3];
    assign dropped   = dropped_reg;

endmodule

`default_nettype wire

// ===== rtl/adc_oversample_averager.sv =====
`default_nettype none

// ADC oversampling block averager. Words carry an action and a signed sample; samples
// belong to channels 0..NUM_CHANNELS-1 in round-robin order, are clamped to 0..2047 and
// summed per channel up to MAX_SAMPLES_PER_CHANNEL samples, beyond which they are dropped
// (the channel slot still advances) and the dropped flag is raised. A report word yields
// one output word with (total * 16) / count per channel for channels 0..3 (0 for an empty
// or absent channel) and the dropped flag, then clears totals, counts and the flag but
// keeps the channel phase. A resync word clears the same and returns the phase to channel
// 0; it gives no output, nor does a sample or the unused action code. A sample or resync
// word leaves the block ready, so the next word may follow at once. A report occupies the
// block while the shared restoring divider, working on a W-bit dividend with W = 15 +
// clog2(MAX_SAMPLES_PER_CHANNEL+1) (W = 22 by default), produces one quotient bit per
// cycle and serves min(NUM_CHANNELS,4) channels one after another. The result sits in an
// output register, so samples keep flowing while it waits to be taken; a second report
// holds in its final state until the previous result has left.

module adc_oversample_averager #(
    parameter int NUM_CHANNELS            = aoa_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_SAMPLES_PER_CHANNEL = aoa_pkg::DEF_MAX_SAMPLES
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          action,
    input  wire logic signed [aoa_pkg::SAMPLE_W-1:0] sample,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [aoa_pkg::AVG_W-1:0]                avg_ch0,
    output logic [aoa_pkg::AVG_W-1:0]                avg_ch1,
    output logic [aoa_pkg::AVG_W-1:0]                avg_ch2,
    output logic [aoa_pkg::AVG_W-1:0]                avg_ch3,
    output logic                                     dropped
);

    // command and status between sequencer and datapath
    aoa_pkg::cmd_t cmd;
    aoa_pkg::sts_t sts;

    // sequencer: decodes the action, walks the divider through each reported channel
    aoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .sts      (sts),
        .cmd      (cmd)
    );

    // accumulators, channel phase, divider and output register
    aoa_datapath #(
        .NUM_CHANNELS            (NUM_CHANNELS),
        .MAX_SAMPLES_PER_CHANNEL (MAX_SAMPLES_PER_CHANNEL)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .avg_ch0   (avg_ch0),
        .avg_ch1   (avg_ch1),
        .avg_ch2   (avg_ch2),
        .avg_ch3   (avg_ch3),
        .dropped   (dropped)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // block configuration under test, matches the rtl defaults
    localparam int NCH = aoa_pkg::DEF_NUM_CHANNELS;
    localparam int CAP = aoa_pkg::DEF_MAX_SAMPLES;
    localparam int SMP_W = aoa_pkg::SAMPLE_W;

    // allowance for one report, used to size the final wait
    localparam int REPORT_CYCLES = 100;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int RANDOM_WORDS = 1700;
    localparam int MIN_REPORTS = 40;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    // one expected report word
    typedef struct packed {
        logic [aoa_pkg::REPORTED-1:0][aoa_pkg::AVG_W-1:0] avg;
        logic                                             dropped;
    } report_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   action;
    logic signed [SMP_W-1:0]      sample;
    logic                         out_valid;
    logic                         out_ready;
    logic [aoa_pkg::AVG_W-1:0]    avg_ch0;
    logic [aoa_pkg::AVG_W-1:0]    avg_ch1;
    logic [aoa_pkg::AVG_W-1:0]    avg_ch2;
    logic [aoa_pkg::AVG_W-1:0]    avg_ch3;
    logic                         dropped;

    logic [aoa_pkg::REPORTED-1:0][aoa_pkg::AVG_W-1:0] got_avg;
    assign got_avg = {avg_ch3, avg_ch2, avg_ch1, avg_ch0};

    // mirror of the averaging state
    logic [16:0] ch_total [NCH];
    logic [6:0]  ch_count [NCH];
    logic [1:0]  ch_phase;
    logic        drop_seen;

    // reports predicted but not yet seen on the output
    report_t expected_reports[$];

    int          mismatch_count = 0;
    int          words_sent = 0;
    int          report_count = 0;
    int          burst_left = 0;
    bit          rx_hold_req = 1'b0;
    int unsigned cycle_count = 0;

    adc_oversample_averager #(
        .NUM_CHANNELS            (NCH),
        .MAX_SAMPLES_PER_CHANNEL (CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .avg_ch0   (avg_ch0),
        .avg_ch1   (avg_ch1),
        .avg_ch2   (avg_ch2),
        .avg_ch3   (avg_ch3),
        .dropped   (dropped)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit, well above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // wipe sums, counts and the drop flag (report and resync both do this)
    task automatic clear_sums();
        for (int i = 0; i < NCH; i++)
        begin
            ch_total[i] = '0;
            ch_count[i] = '0;
        end
        drop_seen = 1'b0;
    endtask

    // apply one accepted word to the mirror, queue a report word if one is due
    task automatic predict_word(input aoa_pkg::action_t act,
                                input logic signed [SMP_W-1:0] smp);
        report_t     rep;
        logic [10:0] level;
        logic [20:0] scaled;
        logic [20:0] quot;
        case (act)
            aoa_pkg::ACT_SAMPLE:
            begin
                // clamp to 0..2047, negatives go to zero
                if (smp[SMP_W-1])
                    level = '0;
                else if (smp[SMP_W-2:0] >= 15'(aoa_pkg::CLAMP_TOP))
                    level = aoa_pkg::CLAMP_TOP;
                else
                    level = smp[10:0];
                // a full channel drops the sample but still uses up its slot
                if (ch_count[ch_phase] >= CAP)
                    drop_seen = 1'b1;
                else
                begin
                    ch_total[ch_phase] = ch_total[ch_phase] + 17'(level);
                    ch_count[ch_phase] = ch_count[ch_phase] + 7'd1;
                end
                ch_phase = 2'((int'(ch_phase) + 1) % NCH);
            end
            aoa_pkg::ACT_REPORT:
            begin
                for (int i = 0; i < aoa_pkg::REPORTED; i++)
                begin
                    if (i >= NCH || ch_count[i] == '0)
                        rep.avg[i] = '0;
                    else
                    begin
                        scaled = {ch_total[i], 4'b0000};
                        quot = scaled / 21'(ch_count[i]);
                        rep.avg[i] = quot[aoa_pkg::AVG_W-1:0];
                    end
                end
                rep.dropped = drop_seen;
                expected_reports.push_back(rep);
                report_count++;
                // phase survives a report
                clear_sums();
            end
            aoa_pkg::ACT_RESYNC:
            begin
                clear_sums();
                ch_phase = '0;
            end
            default:
            begin
                // unused code, no effect
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // sender side, always entered and left at a rising edge
    // ------------------------------------------------------------------

    // offer one word, in bursts with random gaps, and wait for the handshake
    task automatic send_word(input aoa_pkg::action_t act, input logic signed [SMP_W-1:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        sample <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        predict_word(act, smp);
        if (act != aoa_pkg::ACT_NONE)
            words_sent++;
    endtask

    // hold the input idle until every predicted report has come out
    task automatic pause_input();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // sample values weighted toward the clamp edges, full 16-bit range included
    function automatic logic signed [SMP_W-1:0] pick_sample();
        logic signed [SMP_W-1:0] corner [6];
        corner = '{16'sh0000, 16'sh07FF, 16'sh0800, 16'shFFFF, 16'sh7FFF, 16'sh8000};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SMP_W'($urandom_range(0, 2047));
            4, 5:       return SMP_W'($urandom);
            6:          return SMP_W'($urandom_range(2040, 2100));
            7:          return -SMP_W'($urandom_range(1, 32768));
            8:          return corner[$urandom_range(0, 5)];
            default:    return SMP_W'($urandom_range(0, 15));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------

    // out_ready follows a changing stall mode; a hold request forces a long stall
    initial
    begin : rx_stall
        int mode;
        int mode_left;
        int rx_tick;
        mode = 0;
        mode_left = 0;
        rx_tick = 0;
        out_ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (rx_hold_req)
            begin
                // long hold-off, counted here
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ((rx_tick % 8) < 5);
                endcase
            end
        end
    end

    // compare each accepted report word with the oldest prediction
    always @(posedge clk)
    begin : check_reports
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report word with none expected");
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                for (int i = 0; i < aoa_pkg::REPORTED; i++)
                begin
                    if (got_avg[i] !== want.avg[i])
                    begin
                        $error("avg_ch%0d expected %0d got %0d", i, want.avg[i], got_avg[i]);
                        mismatch_count++;
                    end
                end
                if (dropped !== want.dropped)
                begin
                    $error("dropped expected %0d got %0d", want.dropped, dropped);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // report straight out of reset: every channel empty
    task automatic test_empty_report();
        send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
    endtask

    // clamp edges spread over all four channels
    task automatic test_clamp_edges();
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh8000);
        send_word(aoa_pkg::ACT_SAMPLE, 16'shFFFF);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0000);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0001);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh07FE);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh07FF);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0800);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh7FFF);
        send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
    endtask

    // phase is kept across a report, so the next sample lands on channel 3
    task automatic test_phase_kept();
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0123);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0456);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0789);
        send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh03FF);
        send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
    endtask

    // resync clears sums and puts the phase back to channel 0, no report word
    task automatic test_resync();
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0100);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0200);
        send_word(aoa_pkg::ACT_RESYNC, 16'sh7FFF);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0300);
        send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
    endtask

    // unused action code must leave phase and sums alone
    task automatic test_unused_action();
        send_word(aoa_pkg::ACT_NONE, 16'sh1234);
        send_word(aoa_pkg::ACT_SAMPLE, 16'sh0055);
        send_word(aoa_pkg::ACT_NONE, 16'shFFFF);
        send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
    endtask

    // receiver stalls long: results pile up and the block stops taking words
    task automatic test_output_backpressure();
        rx_hold_req = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            repeat ($urandom_range(4, 12)) send_word(aoa_pkg::ACT_SAMPLE, pick_sample());
            send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
        end
        repeat (8) send_word(aoa_pkg::ACT_SAMPLE, pick_sample());
    endtask

    // sender waits for all results before going on
    task automatic test_drain_pause();
        pause_input();
        repeat (5) send_word(aoa_pkg::ACT_SAMPLE, pick_sample());
        send_word(aoa_pkg::ACT_REPORT, 16'sh0000);
    endtask

    // frames of samples closed by a report or a resync; some frames run long
    // enough to fill every channel and hit the cap, a few are broken up
    task automatic test_random_frames();
        int frame_len;
        int roll;
        while (words_sent < RANDOM_WORDS || report_count < MIN_REPORTS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                frame_len = $urandom_range(0, 20);
            else if (roll < 92)
                frame_len = $urandom_range(21, 200);
            else
                frame_len = $urandom_range(250, 300);
            for (int k = 0; k < frame_len; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    send_word(aoa_pkg::ACT_NONE, pick_sample());
                else if (roll < 3)
                    send_word(aoa_pkg::ACT_RESYNC, pick_sample());
                else if (roll < 4)
                    send_word(aoa_pkg::ACT_REPORT, pick_sample());
                else
                    send_word(aoa_pkg::ACT_SAMPLE, pick_sample());
            end
            if ($urandom_range(0, 99) < 88)
                send_word(aoa_pkg::ACT_REPORT, pick_sample());
            else
                send_word(aoa_pkg::ACT_RESYNC, pick_sample());
            if ($urandom_range(0, 7) == 0)
                pause_input();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= aoa_pkg::ACT_SAMPLE;
        sample <= '0;
        ch_phase = '0;
        clear_sums();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_report();
        test_clamp_edges();
        test_phase_kept();
        test_resync();
        test_unused_action();
        test_output_backpressure();
        test_drain_pause();
        test_random_frames();

        // let the last reports come out, then a little extra for stray words
        pause_input();
        repeat (2 * REPORT_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
